// File: sv/mfd_pkg.sv
// Shared types, constants and register codes for the mouse joystick direction unit.
package mfd_pkg;

    // Default geometry of the position path.
    localparam int POS_WIDTH_DEF   = 16;
    localparam int LATCH_DEPTH_DEF = 3;

    // Divider registers are ten bits wide.
    localparam int DIV_W = 10;
    localparam logic [DIV_W-1:0] DIVIDER_RESET = DIV_W'(256);

    // Configuration port geometry.
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIVIDER_X = 1'b0,
        REG_DIVIDER_Y = 1'b1
    } cfg_reg_t;

    // Control port byte values, active low.
    localparam logic [7:0] PORT_IDLE   = 8'hFF;
    localparam logic [7:0] FIRE_MASK   = 8'hEF;
    localparam logic [7:0] PADDLE_HELD = 8'h00;
    localparam logic [7:0] PADDLE_FREE = 8'hFF;

    localparam int BIT_UP    = 0;
    localparam int BIT_DOWN  = 1;
    localparam int BIT_LEFT  = 2;
    localparam int BIT_RIGHT = 3;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIFF,
        ST_CMP
    } seq_state_t;

endpackage

// File: sv/mfd_if.sv
// Item channel interfaces for the mouse joystick direction unit.
interface mfd_in_if
    import mfd_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
);
    logic                        valid;
    logic                        ready;
    logic signed [POS_WIDTH-1:0] target_x;
    logic signed [POS_WIDTH-1:0] target_y;
    logic                        left_pressed;
    logic                        right_pressed;

    modport source (output valid, target_x, target_y, left_pressed, right_pressed,
                    input ready);
    modport sink   (input valid, target_x, target_y, left_pressed, right_pressed,
                    output ready);
endinterface

interface mfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] port_byte;
    logic [7:0] paddle_x;

    modport source (output valid, port_byte, paddle_x, input ready);
    modport sink   (input valid, port_byte, paddle_x, output ready);
endinterface

// File: sv/mfd_div.sv
// Bit-serial signed divider: one quotient bit per cycle, truncating toward zero.
module mfd_div
    import mfd_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [POS_WIDTH-1:0] dividend,
    input  logic [DIV_W-1:0]            divisor,
    output logic                        done,
    output logic signed [POS_WIDTH-1:0] quotient
);

    localparam int CNT_W = $clog2(POS_WIDTH + 1);

    logic [POS_WIDTH-1:0] dvd_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     den_reg;
    logic                 neg_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_W:0]       rem_sh;
    logic                 ge;
    logic [DIV_W:0]       rem_diff;

    // One restoring step: bring in the next dividend bit and try the subtract.
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[POS_WIDTH-1]};
        ge       = (rem_sh >= {1'b0, den_reg});
        rem_diff = rem_sh - {1'b0, den_reg};
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= CNT_W'(POS_WIDTH);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude in at start, quotient bits shift in, sign fixed at the end.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend[POS_WIDTH-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
            neg_reg <= dividend[POS_WIDTH-1];
            // A zero divider acts as one.
            den_reg <= (divisor == '0) ? DIV_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                dvd_reg <= {dvd_reg[POS_WIDTH-2:0], ge};
                rem_reg <= ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            end
            else if (neg_reg)
            begin
                dvd_reg <= ~dvd_reg + 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: sv/mfd_latch.sv
// Delay line of scaled positions; the oldest entry is the comparison point.
module mfd_latch
    import mfd_pkg::*;
#(
    parameter int POS_WIDTH   = POS_WIDTH_DEF,
    parameter int LATCH_DEPTH = LATCH_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic signed [POS_WIDTH-1:0] new_x,
    input  logic signed [POS_WIDTH-1:0] new_y,
    output logic signed [POS_WIDTH-1:0] oldest_x,
    output logic signed [POS_WIDTH-1:0] oldest_y
);

    logic signed [POS_WIDTH-1:0] px_reg [LATCH_DEPTH];
    logic signed [POS_WIDTH-1:0] py_reg [LATCH_DEPTH];

    // Shift toward the oldest slot; the new position enters at the far end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATCH_DEPTH; i++)
            begin
                px_reg[i] <= '0;
                py_reg[i] <= '0;
            end
        end
        else if (push)
        begin
            for (int i = 0; i < LATCH_DEPTH - 1; i++)
            begin
                px_reg[i] <= px_reg[i+1];
                py_reg[i] <= py_reg[i+1];
            end
            px_reg[LATCH_DEPTH-1] <= new_x;
            py_reg[LATCH_DEPTH-1] <= new_y;
        end
    end

    assign oldest_x = px_reg[0];
    assign oldest_y = py_reg[0];

endmodule

// File: sv/mouse_joystick_mode_direction_unit.sv
// Top level of the mouse joystick direction unit: sequencer, compare stage and output register.
//
// Each item runs from acceptance to a loaded result through these steps: the two bit-serial
// dividers scale X and Y side by side, the sequencer sees both dividers finish, the deltas are
// formed against the position latched LATCH_DEPTH items earlier and registered, and the
// direction is classified and loaded into the output register, which waits while the output
// holds a result not yet read. The input is ready again the cycle after the result loads, so
// the block takes no new item until the last one's result has loaded.
// The block holds one item at a time; the result sits in an output register, so a new item
// is taken while the previous result still waits to be read. The divider registers may be
// written at any time the block is idle and take effect on the next item.
module mouse_joystick_mode_direction_unit
    import mfd_pkg::*;
#(
    parameter int POS_WIDTH   = POS_WIDTH_DEF,
    parameter int LATCH_DEPTH = LATCH_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    mfd_in_if.sink               in_ch,
    mfd_out_if.source            out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIV_W-1:0]     cfg_data
);

    seq_state_t state_reg, state_next;

    logic [DIV_W-1:0] divider_x_reg;
    logic [DIV_W-1:0] divider_y_reg;

    logic left_reg;
    logic right_reg;

    logic signed [POS_WIDTH:0] dx_reg, dx_next;
    logic signed [POS_WIDTH:0] dy_reg, dy_next;

    logic       out_valid_reg;
    logic [7:0] port_byte_reg, port_byte_next;
    logic [7:0] paddle_x_reg;

    logic accept;
    logic div_start;
    logic push;
    logic out_load;

    logic                        done_x, done_y;
    logic signed [POS_WIDTH-1:0] mx, my;
    logic signed [POS_WIDTH-1:0] oldest_x, oldest_y;

    logic [POS_WIDTH:0]          ax, ay, m;
    logic signed [POS_WIDTH+2:0] dx2, dy2, ms, mneg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_x_reg <= DIVIDER_RESET;
            divider_y_reg <= DIVIDER_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DIVIDER_X: divider_x_reg <= cfg_data;
                REG_DIVIDER_Y: divider_y_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Scaling units for both axes.
    mfd_div #(.POS_WIDTH(POS_WIDTH)) u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_ch.target_x),
        .divisor  (divider_x_reg),
        .done     (done_x),
        .quotient (mx)
    );

    mfd_div #(.POS_WIDTH(POS_WIDTH)) u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_ch.target_y),
        .divisor  (divider_y_reg),
        .done     (done_y),
        .quotient (my)
    );

    // Past positions.
    mfd_latch #(.POS_WIDTH(POS_WIDTH), .LATCH_DEPTH(LATCH_DEPTH)) u_latch (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .new_x    (mx),
        .new_y    (my),
        .oldest_x (oldest_x),
        .oldest_y (oldest_y)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (done_x && done_y)
                begin
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ch.ready = 1'b0;
        push        = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE: in_ch.ready = 1'b1;
            ST_DIV:  ;
            ST_DIFF: push = 1'b1;
            ST_CMP:  out_load = !out_valid_reg || out_ch.ready;
            default: ;
        endcase
    end

    assign accept    = in_ch.valid && in_ch.ready;
    assign div_start = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Deltas against the oldest latched position.
    always_comb
    begin
        dx_next = $signed({mx[POS_WIDTH-1], mx}) - $signed({oldest_x[POS_WIDTH-1], oldest_x});
        dy_next = $signed({oldest_y[POS_WIDTH-1], oldest_y}) - $signed({my[POS_WIDTH-1], my});
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg  <= in_ch.left_pressed;
            right_reg <= in_ch.right_pressed;
        end
        if (push)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
    end

    // Direction classification: a bit clears when twice its delta passes the larger magnitude.
    always_comb
    begin
        ax   = dx_reg[POS_WIDTH] ? (~dx_reg + 1'b1) : dx_reg;
        ay   = dy_reg[POS_WIDTH] ? (~dy_reg + 1'b1) : dy_reg;
        m    = (ax > ay) ? ax : ay;
        dx2  = $signed({dx_reg[POS_WIDTH], dx_reg, 1'b0});
        dy2  = $signed({dy_reg[POS_WIDTH], dy_reg, 1'b0});
        ms   = $signed({2'b00, m});
        mneg = -ms;

        port_byte_next = PORT_IDLE;
        if (dy2 < mneg)
        begin
            port_byte_next[BIT_UP] = 1'b0;
        end
        if (dy2 > ms)
        begin
            port_byte_next[BIT_DOWN] = 1'b0;
        end
        if (dx2 < mneg)
        begin
            port_byte_next[BIT_LEFT] = 1'b0;
        end
        if (dx2 > ms)
        begin
            port_byte_next[BIT_RIGHT] = 1'b0;
        end
        // The left button pulls the fire line low.
        if (left_reg)
        begin
            port_byte_next = port_byte_next & FIRE_MASK;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            port_byte_reg <= port_byte_next;
            paddle_x_reg  <= right_reg ? PADDLE_HELD : PADDLE_FREE;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.port_byte = port_byte_reg;
    assign out_ch.paddle_x  = paddle_x_reg;

endmodule

// File: sv/mfd_checker.sv
// Port-level checker for the mouse joystick direction unit, bound to the top level.
module mfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] port_byte,
    input logic [7:0] paddle_x
);

    // Only one item is in flight, so ready drops right after an item is taken.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is still in work");

    // A held result stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(port_byte) && $stable(paddle_x))
        else $error("result changed while stalled");

    // The unused upper bits of the port stay high.
    a_upper_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> port_byte[7:5] == 3'b111)
        else $error("upper port bits not high");

    // Opposite directions are never both active.
    a_no_opposite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (port_byte[0] || port_byte[1]) && (port_byte[2] || port_byte[3]))
        else $error("opposite directions both active");

    // The paddle value is either fully released or fully pressed.
    a_paddle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> paddle_x == 8'h00 || paddle_x == 8'hFF)
        else $error("paddle value out of its two codes");

endmodule

bind mouse_joystick_mode_direction_unit mfd_checker u_mfd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .port_byte (out_ch.port_byte),
    .paddle_x  (out_ch.paddle_x)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench for the mouse joystick direction unit, with directed and random pointer motion.
module tb;
    import mfd_pkg::*;

    localparam int POS_W        = POS_WIDTH_DEF;
    localparam int DEPTH        = LATCH_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 2 * (POS_W + 4);
    localparam int CHUNK_ITEMS  = 70;
    localparam int POS_MIN      = -(1 << (POS_W - 1));
    localparam int POS_MAX      = (1 << (POS_W - 1)) - 1;

    typedef struct {
        logic [7:0] port_byte;
        logic [7:0] paddle_x;
    } joy_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    cfg_reg_t         cfg_index;
    logic [DIV_W-1:0] cfg_data;

    mfd_in_if #(.POS_WIDTH(POS_W)) in_ch ();
    mfd_out_if                     out_ch ();

    mouse_joystick_mode_direction_unit #(
        .POS_WIDTH   (POS_W),
        .LATCH_DEPTH (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Expected state of the block: dividers and the scaled position history, oldest first.
    logic [DIV_W-1:0]        cur_div_x = DIVIDER_RESET;
    logic [DIV_W-1:0]        cur_div_y = DIVIDER_RESET;
    logic signed [POS_W-1:0] hist_x [DEPTH] = '{default: '0};
    logic signed [POS_W-1:0] hist_y [DEPTH] = '{default: '0};

    joy_result_t pending_joy [$];
    joy_result_t head_joy;
    int          error_count = 0;
    int          cycle_count = 0;

    // Idle rates and the long receiver hold-off.
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int stall_order  = 0;
    int stall_seen   = 0;
    int hold_left    = 0;

    // Random walk position of the pointer.
    int walk_x = 0;
    int walk_y = 0;

    // A divider of zero behaves as one; division truncates toward zero.
    function automatic logic signed [POS_W-1:0] scale_pos(input logic signed [POS_W-1:0] raw,
                                                          input logic [DIV_W-1:0] div);
        int d;
        d = (div == '0) ? 1 : int'(div);
        return POS_W'(int'(raw) / d);
    endfunction

    // Works out the port byte and paddle value for one item and advances the history.
    function automatic joy_result_t step_joystick(input logic signed [POS_W-1:0] x,
                                                  input logic signed [POS_W-1:0] y,
                                                  input logic lb, input logic rb);
        logic signed [POS_W-1:0] mx;
        logic signed [POS_W-1:0] my;
        int                      dx;
        int                      dy;
        int                      ax;
        int                      ay;
        int                      m;
        int                      i;
        joy_result_t             r;
        mx = scale_pos(x, cur_div_x);
        my = scale_pos(y, cur_div_y);
        dx = int'(mx) - int'(hist_x[0]);
        dy = int'(hist_y[0]) - int'(my);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        m  = (ax > ay) ? ax : ay;
        r.port_byte = PORT_IDLE;
        // A direction fires once twice its delta passes the larger absolute delta.
        if (m > 0)
        begin
            if (2 * dy < -m)
                r.port_byte[BIT_UP] = 1'b0;
            if (2 * dy > m)
                r.port_byte[BIT_DOWN] = 1'b0;
            if (2 * dx < -m)
                r.port_byte[BIT_LEFT] = 1'b0;
            if (2 * dx > m)
                r.port_byte[BIT_RIGHT] = 1'b0;
        end
        for (i = 0; i < DEPTH - 1; i++)
        begin
            hist_x[i] = hist_x[i + 1];
            hist_y[i] = hist_y[i + 1];
        end
        hist_x[DEPTH - 1] = mx;
        hist_y[DEPTH - 1] = my;
        if (lb)
            r.port_byte = r.port_byte & FIRE_MASK;
        r.paddle_x = rb ? PADDLE_HELD : PADDLE_FREE;
        return r;
    endfunction

    function automatic int clamp_pos(input int v);
        if (v < POS_MIN)
            return POS_MIN;
        if (v > POS_MAX)
            return POS_MAX;
        return v;
    endfunction

    // Small dividers dominate so that motion stays visible; the extremes come up often.
    function automatic logic [DIV_W-1:0] pick_divider();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return '0;
        if (r < 20)
            return DIV_W'(1023);
        if (r < 30)
            return DIV_W'(1);
        if (r < 70)
            return DIV_W'($urandom_range(2, 16));
        return DIV_W'($urandom_range(1, 1023));
    endfunction

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random ready, or a long hold-off when one is ordered.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (stall_seen != stall_order)
        begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            stall_seen   <= stall_order;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check each result against the oldest expectation, then predict each accepted item.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_joy.size() == 0)
            begin
                $display("%0t: unexpected result, port_byte %02h paddle_x %02h",
                         $time, out_ch.port_byte, out_ch.paddle_x);
                error_count++;
            end
            else
            begin
                head_joy = pending_joy.pop_front();
                if (head_joy.port_byte !== out_ch.port_byte)
                begin
                    $display("%0t: port_byte mismatch, expected %02h, actual %02h",
                             $time, head_joy.port_byte, out_ch.port_byte);
                    error_count++;
                end
                if (head_joy.paddle_x !== out_ch.paddle_x)
                begin
                    $display("%0t: paddle_x mismatch, expected %02h, actual %02h",
                             $time, head_joy.paddle_x, out_ch.paddle_x);
                    error_count++;
                end
            end
        end
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            pending_joy.push_back(step_joystick(in_ch.target_x, in_ch.target_y,
                                                in_ch.left_pressed, in_ch.right_pressed));
        end
    end

    // Offers one item, at times after a random gap, and returns at the edge that accepts it.
    task automatic send_move(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                             input logic lb, input logic rb);
        int gap;
        if ($urandom_range(99) < tx_idle_pct)
        begin
            gap = $urandom_range(1, 24);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.target_x      <= x;
        in_ch.target_y      <= y;
        in_ch.left_pressed  <= lb;
        in_ch.right_pressed <= rb;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Stops offering items and waits for every outstanding result.
    task automatic drain_moves();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_joy.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both dividers; only called while the block is idle.
    task automatic set_dividers(input logic [DIV_W-1:0] div_x, input logic [DIV_W-1:0] div_y);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DIVIDER_X;
        cfg_data  <= div_x;
        @(posedge clk);
        cfg_index <= REG_DIVIDER_Y;
        cfg_data  <= div_y;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_div_x = div_x;
        cur_div_y = div_y;
    endtask

    // Reset dividers and a cleared history, with every button combination and extreme positions.
    task automatic test_reset_state();
        send_move(0, 0, 1'b0, 1'b0);
        send_move(0, 0, 1'b1, 1'b0);
        send_move(0, 0, 1'b0, 1'b1);
        send_move(0, 0, 1'b1, 1'b1);
        send_move(32767, -32768, 1'b0, 1'b0);
        send_move(-32768, 32767, 1'b1, 1'b1);
    endtask

    // A zero divider passes positions through unscaled; the largest divider crushes them.
    task automatic test_divider_extremes();
        drain_moves();
        set_dividers('0, DIV_W'(1023));
        send_move(32767, 32767, 1'b0, 1'b1);
        send_move(-32768, -32768, 1'b1, 1'b0);
        send_move(255, -1023, 1'b0, 1'b0);
        drain_moves();
        set_dividers(DIV_W'(1023), '0);
        send_move(32767, 32767, 1'b0, 1'b0);
        send_move(-32768, -32768, 1'b0, 1'b1);
        send_move(-1023, 255, 1'b1, 1'b0);
    endtask

    // Single directions, a diagonal, no movement, and deltas sitting exactly on the threshold.
    task automatic test_direction_thresholds();
        drain_moves();
        set_dividers(DIV_W'(1), DIV_W'(1));
        send_move(0, 0, 1'b0, 1'b0);
        send_move(0, 0, 1'b0, 1'b0);
        send_move(0, 0, 1'b0, 1'b0);
        send_move(100, 0, 1'b0, 1'b0);
        send_move(0, 100, 1'b0, 1'b0);
        send_move(-100, -50, 1'b0, 1'b0);
        send_move(100, 0, 1'b1, 1'b0);
        send_move(1, 101, 1'b0, 1'b0);
        send_move(-100, -51, 1'b0, 1'b1);
    endtask

    // Mostly a random walk in steps of a few scaled units, with some still and some wild items.
    task automatic run_motion(input int count);
        int i;
        int kind;
        int span_x;
        int span_y;
        span_x = 12 * ((cur_div_x == '0) ? 1 : int'(cur_div_x));
        span_y = 12 * ((cur_div_y == '0) ? 1 : int'(cur_div_y));
        for (i = 0; i < count; i++)
        begin
            kind = $urandom_range(99);
            if (kind < 70)
            begin
                walk_x = clamp_pos(walk_x + int'($urandom_range(0, 2 * span_x)) - span_x);
                walk_y = clamp_pos(walk_y + int'($urandom_range(0, 2 * span_y)) - span_y);
            end
            else if (kind >= 80)
            begin
                walk_x = int'($signed(POS_W'($urandom())));
                walk_y = int'($signed(POS_W'($urandom())));
            end
            send_move(POS_W'(walk_x), POS_W'(walk_y), 1'($urandom()), 1'($urandom()));
        end
    endtask

    // One idling pattern over several divider settings.
    task automatic test_random_motion(input int tx_pct, input int rx_pct, input int chunks);
        int c;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (c = 0; c < chunks; c++)
        begin
            drain_moves();
            set_dividers(pick_divider(), pick_divider());
            run_motion(CHUNK_ITEMS);
        end
    endtask

    // The receiver holds off long enough to fill the block, then the sender waits for a drain.
    task automatic test_backpressure();
        drain_moves();
        set_dividers(DIV_W'(4), DIV_W'(4));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_order <= stall_order + 1;
        run_motion(12);
        drain_moves();
        run_motion(4);
    endtask

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= REG_DIVIDER_X;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.target_x      <= '0;
        in_ch.target_y      <= '0;
        in_ch.left_pressed  <= 1'b0;
        in_ch.right_pressed <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_divider_extremes();
        test_direction_thresholds();
        test_random_motion(18, 54, 5);
        test_random_motion(54, 18, 5);
        test_random_motion(0, 0, 5);
        test_backpressure();

        drain_moves();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
